@@ hdl/nvfp4_q8_dot_accumulate_top_defines.svh @@
// Assertion macros used by the FP4 by int8 dot accumulate controller
`ifndef NVFP4_Q8_DOT_ACCUMULATE_TOP_DEFINES_SVH
`define NVFP4_Q8_DOT_ACCUMULATE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define NQD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define NQD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

// Invariant that holds at every clock outside reset
`define NQD_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error(msg);

`endif

@@ hdl/nqd_pkg.sv @@
// Shared types, constants and decode functions of the FP4 by int8 dot accumulator
package nqd_pkg;

	localparam int unsigned ACC_W   = 64;
	localparam int unsigned PROD1_W = 11;  // codebook magnitude times activation magnitude
	localparam int unsigned WH_W    = 29;  // weight scale units times fp16 mantissa
	localparam int unsigned MAG_W   = 40;  // full term magnitude before the exponent shift
	localparam int unsigned SHIFT_W = 5;
	localparam int unsigned WSC_W   = 18;  // decoded UE4M3 scale in units of 2^-9

	localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	localparam logic [7:0] UE_ZERO_CODE = 8'h7f;
	localparam logic [4:0] HEXP_SPECIAL = 5'd31;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MULT1,
		ST_MULT2,
		ST_TERM,
		ST_ADD_LO,
		ST_ADD_HI,
		ST_EMIT
	} nqd_state_t;

	typedef struct packed {
		logic load;
		logic mult1;
		logic mult2;
		logic term;
		logic add_lo;
		logic add_hi;
		logic emit;
	} nqd_cmd_t;

	typedef struct packed {
		logic last;
	} nqd_status_t;

	// Magnitude of an FP4 code, sign bit excluded
	function automatic logic [3:0] fp4_mag(input logic [2:0] code);
		logic [3:0] mag;
		case (code)
			3'd0:    mag = 4'd0;
			3'd1:    mag = 4'd1;
			3'd2:    mag = 4'd2;
			3'd3:    mag = 4'd3;
			3'd4:    mag = 4'd4;
			3'd5:    mag = 4'd6;
			3'd6:    mag = 4'd8;
			3'd7:    mag = 4'd12;
			default: mag = 4'd0;
		endcase
		return mag;
	endfunction

	// UE4M3 scale as an integer count of 2^-9
	function automatic logic [WSC_W-1:0] ue4m3_units(input logic [7:0] code);
		logic [3:0]       e;
		logic [2:0]       m;
		logic [WSC_W-1:0] val;
		e = code[6:3];
		m = code[2:0];
		if (code == 8'h00 || code == UE_ZERO_CODE) begin
			val = '0;
		end else if (e == 4'd0) begin
			val = WSC_W'(m);
		end else begin
			val = WSC_W'({1'b1, m}) << (e - 4'd1);
		end
		return val;
	endfunction

endpackage

@@ hdl/nqd_datapath.sv @@
// Datapath: input capture, two multiply stages, term scaling and saturating accumulate
module nqd_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  nqd_pkg::nqd_cmd_t        cmd,
	output nqd_pkg::nqd_status_t     sts,
	input  logic [7:0]               packed_byte,
	input  logic [7:0]               scale_code,
	input  logic signed [7:0]        act_low,
	input  logic signed [7:0]        act_high,
	input  logic [15:0]              act_scale,
	input  logic                     last,
	output logic signed [63:0]       dot_sum,
	output logic                     overflow
);
	import nqd_pkg::*;

	typedef struct packed {
		logic [ACC_W-1:0] val;
		logic             ovf;
	} sat_res_t;

	// Scale a magnitude by 2^shift, apply sign and saturate to int64
	function automatic sat_res_t make_term(input logic [MAG_W-1:0] mag, input logic neg,
		input logic [SHIFT_W-1:0] shift);
		logic [MAG_W+28:0] sh;
		sat_res_t          res;
		sh = {29'b0, mag} << shift;
		res.ovf = 1'b0;
		if (sh[MAG_W+28:ACC_W] != '0 || (sh[ACC_W-1] && sh[ACC_W-2:0] != '0)) begin
			res.ovf = 1'b1;
			res.val = neg ? ACC_MIN : ACC_MAX;
		end else if (sh[ACC_W-1]) begin
			res.ovf = !neg;
			res.val = neg ? ACC_MIN : ACC_MAX;
		end else if (neg) begin
			res.val = '0 - sh[ACC_W-1:0];
		end else begin
			res.val = sh[ACC_W-1:0];
		end
		return res;
	endfunction

	// Signed add that clamps on overflow
	function automatic sat_res_t sat_add(input logic [ACC_W-1:0] a, input logic [ACC_W-1:0] b);
		logic [ACC_W-1:0] sum;
		sat_res_t         res;
		sum = a + b;
		res.ovf = (a[ACC_W-1] == b[ACC_W-1]) && (sum[ACC_W-1] != a[ACC_W-1]);
		res.val = res.ovf ? (a[ACC_W-1] ? ACC_MIN : ACC_MAX) : sum;
		return res;
	endfunction

	// captured item
	logic [7:0]  byte_q;
	logic [7:0]  scale_q;
	logic [7:0]  act_lo_q;
	logic [7:0]  act_hi_q;
	logic [15:0] hscale_q;
	logic        last_q;

	logic [PROD1_W-1:0] p_lo_q, p_hi_q;
	logic [WH_W-1:0]    wh_q;
	logic [MAG_W-1:0]   mag_lo_q, mag_hi_q;
	logic [ACC_W-1:0]   term_lo_q, term_hi_q;
	logic [ACC_W-1:0]   acc_q;
	logic               ovf_q;
	logic [ACC_W-1:0]   dot_sum_q;
	logic               overflow_q;

	logic [4:0]         hexp;
	logic               hinf;
	logic [10:0]        hmant;
	logic [SHIFT_W-1:0] shift;
	logic [7:0]         amag_lo, amag_hi;
	logic [11:0]        p_lo_full, p_hi_full;
	logic [WH_W-1:0]    wh_prod;
	logic               neg_lo, neg_hi;
	sat_res_t           t_lo, t_hi, add_res;

	// fp16 scale fields
	assign hexp  = hscale_q[14:10];
	assign hinf  = (hexp == HEXP_SPECIAL);
	assign hmant = {hexp != 5'd0, hscale_q[9:0]};
	assign shift = (hexp != 5'd0) ? (hexp - 5'd1) : '0;

	// activation magnitudes and term signs
	assign amag_lo = act_lo_q[7] ? (~act_lo_q + 8'd1) : act_lo_q;
	assign amag_hi = act_hi_q[7] ? (~act_hi_q + 8'd1) : act_hi_q;
	assign neg_lo  = hscale_q[15] ^ byte_q[3] ^ act_lo_q[7];
	assign neg_hi  = hscale_q[15] ^ byte_q[7] ^ act_hi_q[7];

	// first multiply stage
	assign p_lo_full = 12'(fp4_mag(byte_q[2:0])) * 12'(amag_lo);
	assign p_hi_full = 12'(fp4_mag(byte_q[6:4])) * 12'(amag_hi);
	assign wh_prod   = WH_W'(ue4m3_units(scale_q)) * WH_W'(hmant);

	assign t_lo = make_term(mag_lo_q, neg_lo, shift);
	assign t_hi = make_term(mag_hi_q, neg_hi, shift);

	// one adder serves both terms, low element first
	assign add_res = sat_add(acc_q, cmd.add_hi ? term_hi_q : term_lo_q);

	// capture, multiply, term and output registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q   <= packed_byte;
			scale_q  <= scale_code;
			act_lo_q <= act_low;
			act_hi_q <= act_high;
			hscale_q <= act_scale;
			last_q   <= last;
		end
		if (cmd.mult1) begin
			p_lo_q <= p_lo_full[PROD1_W-1:0];
			p_hi_q <= p_hi_full[PROD1_W-1:0];
			wh_q   <= wh_prod;
		end
		if (cmd.mult2) begin
			mag_lo_q <= MAG_W'(p_lo_q) * MAG_W'(wh_q);
			mag_hi_q <= MAG_W'(p_hi_q) * MAG_W'(wh_q);
		end
		if (cmd.term) begin
			term_lo_q <= hinf ? '0 : t_lo.val;
			term_hi_q <= hinf ? '0 : t_hi.val;
		end
		if (cmd.emit) begin
			dot_sum_q  <= acc_q;
			overflow_q <= ovf_q;
		end
	end

	// accumulator and sticky overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.emit) begin
			acc_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.term) begin
			if (hinf || t_lo.ovf || t_hi.ovf) begin
				ovf_q <= 1'b1;
			end
		end else if (cmd.add_lo || cmd.add_hi) begin
			acc_q <= add_res.val;
			if (add_res.ovf) begin
				ovf_q <= 1'b1;
			end
		end
	end

	assign sts.last = last_q;
	assign dot_sum  = dot_sum_q;
	assign overflow = overflow_q;

endmodule

@@ hdl/nqd_ctrl.sv @@
// Controller: sequences each item through the datapath and holds the result valid flag
`include "nvfp4_q8_dot_accumulate_top_defines.svh"

module nqd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output nqd_pkg::nqd_cmd_t    cmd,
	input  nqd_pkg::nqd_status_t sts
);
	import nqd_pkg::*;

	nqd_state_t state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_MULT1;
			ST_MULT1:  state_d = ST_MULT2;
			ST_MULT2:  state_d = ST_TERM;
			ST_TERM:   state_d = ST_ADD_LO;
			ST_ADD_LO: state_d = ST_ADD_HI;
			ST_ADD_HI: state_d = sts.last ? ST_EMIT : ST_IDLE;
			ST_EMIT:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_MULT1:  cmd.mult1  = 1'b1;
			ST_MULT2:  cmd.mult2  = 1'b1;
			ST_TERM:   cmd.term   = 1'b1;
			ST_ADD_LO: cmd.add_lo = 1'b1;
			ST_ADD_HI: cmd.add_hi = 1'b1;
			ST_EMIT:   cmd.emit   = out_free;
			default:   cmd        = '0;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`NQD_ASSERT_NOW(a_emit_free, clk, arst_n, cmd.emit, !out_valid_q || !out_stall, "emit while output register held")
	`NQD_ASSERT_NEXT(a_accept_starts, clk, arst_n, in_valid && !in_stall, state_q == ST_MULT1, "accepted item did not start")
	`NQD_ASSERT_NEXT(a_last_emits, clk, arst_n, state_q == ST_ADD_HI && sts.last, state_q == ST_EMIT, "last item skipped emit")
	`NQD_ASSERT_ALWAYS(a_cmd_onehot, clk, arst_n, $onehot0({cmd.load, cmd.mult1, cmd.mult2, cmd.term, cmd.add_lo, cmd.add_hi, cmd.emit}), "overlapping datapath commands")

endmodule

@@ hdl/nvfp4_q8_dot_accumulate_top.sv @@
// Top level of the FP4 weight by int8 activation dot accumulator
//
// Input channel (in_valid/in_stall): one item per packed weight byte, with
// its UE4M3 sub-block scale, the two int8 activations and the fp16 block
// scale. Each item adds two exact terms into a 64-bit accumulator with LSB
// 2^-34, saturating and flagging on overflow or an inf/NaN scale.
// Output channel (out_valid/out_stall): one result, dot_sum and overflow,
// for each item with last set; the accumulator and flag then clear.
// Sequencing: in_stall stays high until the item in flight is done; the
// sequencer walks each item through two multiply steps, term scaling and
// one shared accumulator adder used twice. An item with last then goes
// to an emit state, which loads the output register and raises out_valid.
// The output register parts the two sides: items keep being accepted while a
// result waits; a last item whose result finds the register still held under
// stall waits until that result is taken.
// Reset (arst_n low) clears the accumulator, the flag and out_valid.
module nvfp4_q8_dot_accumulate_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         packed_byte,
	input  logic [7:0]         scale_code,
	input  logic signed [7:0]  act_low,
	input  logic signed [7:0]  act_high,
	input  logic [15:0]        act_scale,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [63:0] dot_sum,
	output logic               overflow
);
	import nqd_pkg::*;

	nqd_cmd_t    cmd;
	nqd_status_t sts;

	nqd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	nqd_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.packed_byte (packed_byte),
		.scale_code  (scale_code),
		.act_low     (act_low),
		.act_high    (act_high),
		.act_scale   (act_scale),
		.last        (last),
		.dot_sum     (dot_sum),
		.overflow    (overflow)
	);

endmodule
